>>> rtl/loudness_gain_rider_defines.svh
// Assertion helper macros for the gain rider.
`ifndef LOUDNESS_GAIN_RIDER_DEFINES_SVH
`define LOUDNESS_GAIN_RIDER_DEFINES_SVH
`ifndef SYNTHESIS
`define LGR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LGR_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGR_ASSERT(label, clk, rst_n, prop, msg)
`define LGR_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/lgr_pkg.sv
package lgr_pkg;
    localparam int SAMPLE_BITS = 14;

    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_THRESH   = 3'd1;
    localparam logic [2:0] REG_HYST     = 3'd2;
    localparam logic [2:0] REG_MAXCORR  = 3'd3;
    localparam logic [2:0] REG_DEADBAND = 3'd4;
    localparam logic [2:0] REG_ATTACK   = 3'd5;
    localparam logic [2:0] REG_RELEASE  = 3'd6;
endpackage

>>> rtl/lgr_stream_if.sv
interface lgr_stream_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/lgr_front.sv
module lgr_front
    import lgr_pkg::*;
#(
    parameter int LEVEL_BITS = 16,
    parameter int MAX_BLOCK  = 8192,
    parameter int QW         = LEVEL_BITS + SAMPLE_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [LEVEL_BITS-1:0]  in_level,
    input  logic [SAMPLE_BITS-1:0] in_samples,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [QW-1:0] q_data
);
    localparam logic [SAMPLE_BITS:0] MAXB = (SAMPLE_BITS+1)'(MAX_BLOCK);

    logic          full_reg, full_next;
    logic [QW-1:0] data_reg;
    logic [SAMPLE_BITS-1:0] n_sat;

    // saturate block length
    always_comb
    begin
        if ({1'b0, in_samples} > MAXB)
            n_sat = MAXB[SAMPLE_BITS-1:0];
        else
            n_sat = in_samples;
    end

    assign in_ready = !full_reg || q_ready;
    assign q_valid  = full_reg;
    assign q_data   = data_reg;

    always_comb
    begin
        full_next = full_reg;
        if (q_valid && q_ready)
            full_next = 1'b0;
        if (in_valid && in_ready)
            full_next = 1'b1;
    end

    // hold one request for the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= {in_level, n_sat};
    end
endmodule

>>> rtl/lgr_back.sv
module lgr_back
    import lgr_pkg::*;
#(
    parameter int LEVEL_BITS = 16,
    parameter int COEFF_BITS = 16,
    parameter int QW         = LEVEL_BITS + SAMPLE_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [QW-1:0] q_data,
    input  logic signed [LEVEL_BITS-1:0] target,
    input  logic signed [LEVEL_BITS-1:0] thresh,
    input  logic [LEVEL_BITS-2:0] hyst,
    input  logic [LEVEL_BITS-2:0] maxcorr,
    input  logic [LEVEL_BITS-2:0] deadband,
    input  logic [COEFF_BITS-1:0] attack,
    input  logic [COEFF_BITS-1:0] release_c,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [LEVEL_BITS-1:0] out_gain,
    output logic          out_gate,
    output logic          out_att,
    output logic          busy
);
    localparam int LW = LEVEL_BITS + 3;
    localparam int CW = COEFF_BITS + 1;
    localparam int CNTW = $clog2(SAMPLE_BITS + 1);
    localparam logic [CW-1:0] ONE = CW'(1) << COEFF_BITS;
    localparam logic [2*CW-1:0] HALF = (2*CW)'(1) << (COEFF_BITS - 1);
    localparam logic signed [LW-1:0] GMAX = LW'((1 << (LEVEL_BITS - 1)) - 1);
    localparam logic signed [LW-1:0] GMIN = ~GMAX;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_POW   = 5'b00100,
        S_SCALE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic gate_reg, att_reg, attout_reg;
    logic signed [LEVEL_BITS-1:0] gain_reg;
    logic signed [LW-1:0] corr_reg, x_reg;
    logic [SAMPLE_BITS-1:0] n_reg;
    logic [LEVEL_BITS-1:0] lvl_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CW-1:0] acc_reg, base_reg;
    logic [LEVEL_BITS-1:0] res_reg;
    logic toggle_reg;

    logic signed [LW-1:0] lev, lev2, th2, mc, corr, agc, agg, delta, db, hy;
    logic gate_new, att_new;
    logic [2*CW-1:0] pm;
    logic [CW-1:0] mop, rnd;
    logic [LW-1:0] xmag;
    logic [LW+CW-1:0] sp;
    logic signed [LW-1:0] scaled, g;

    assign lev  = LW'($signed(lvl_reg));
    assign lev2 = lev <<< 1;
    assign th2  = LW'(thresh) <<< 1;
    assign mc   = LW'({1'b0, maxcorr});
    assign db   = LW'({1'b0, deadband});
    assign hy   = LW'({1'b0, hyst});

    // classify: gate, correction, attack choice
    always_comb
    begin
        gate_new = gate_reg;
        if (gate_reg && lev2 < th2 - hy)
            gate_new = 1'b0;
        else if (!gate_reg && lev2 > th2 + hy)
            gate_new = 1'b1;
        corr = LW'(target) - lev;
        if (corr > mc)
            corr = mc;
        if (corr < -mc)
            corr = -mc;
        agc   = corr[LW-1] ? -corr : corr;
        agg   = gain_reg[LEVEL_BITS-1] ? -LW'(gain_reg) : LW'(gain_reg);
        delta = agc - agg;
        att_new = att_reg;
        if (delta > db)
            att_new = 1'b1;
        else if (delta < -db)
            att_new = 1'b0;
    end

    // one shared multiplier: acc*base and base*base alternate
    assign mop = toggle_reg ? base_reg : acc_reg;
    assign pm  = mop * base_reg + HALF;
    assign rnd = pm[COEFF_BITS +: CW];

    // signed scale with ties away from zero
    assign xmag   = x_reg[LW-1] ? LW'(-x_reg) : LW'(x_reg);
    assign sp     = xmag * acc_reg + (LW+CW)'(HALF);
    assign scaled = x_reg[LW-1] ? -LW'(sp[LW+CW-1:COEFF_BITS])
                                : LW'(sp[LW+CW-1:COEFF_BITS]);
    always_comb
    begin
        g = gate_reg ? corr_reg + scaled : scaled;
        if (g > GMAX)
            g = GMAX;
        if (g < GMIN)
            g = GMIN;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_SETUP;
            S_SETUP: state_next = S_POW;
            S_POW:   if (toggle_reg && cnt_reg == CNTW'(SAMPLE_BITS - 1))
                         state_next = S_SCALE;
            S_SCALE: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_ready   = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_gain  = res_reg;
    assign out_gate  = gate_reg;
    assign out_att   = attout_reg;
    assign busy      = state_reg != S_IDLE;

    // advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gate_reg   <= 1'b1;
            att_reg    <= 1'b0;
            gain_reg   <= '0;
            toggle_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SETUP)
            begin
                gate_reg <= gate_new;
                if (gate_new)
                    att_reg <= att_new;
                toggle_reg <= 1'b0;
                cnt_reg    <= '0;
            end
            if (state_reg == S_POW)
            begin
                toggle_reg <= !toggle_reg;
                if (toggle_reg)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_SCALE)
                gain_reg <= g[LEVEL_BITS-1:0];
        end
    end

    // datapath; capture the whole request, the front may refill at once
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            n_reg   <= q_data[SAMPLE_BITS-1:0];
            lvl_reg <= q_data[QW-1:SAMPLE_BITS];
        end
        if (state_reg == S_SETUP)
        begin
            corr_reg   <= corr;
            x_reg      <= gate_new ? LW'(gain_reg) - corr : LW'(gain_reg);
            base_reg   <= {1'b0, (gate_new && att_new) ? attack : release_c};
            attout_reg <= gate_new && att_new;
            acc_reg    <= ONE;
        end
        if (state_reg == S_POW)
        begin
            if (!toggle_reg)
            begin
                if (n_reg[cnt_reg[CNTW-1:0]])
                    acc_reg <= rnd;
            end
            else
                base_reg <= rnd;
        end
        if (state_reg == S_SCALE)
            res_reg <= g[LEVEL_BITS-1:0];
    end
endmodule

>>> rtl/loudness_gain_rider.sv
// From input request to result the back end runs setup, 28 powering steps, scale and out.
// The back end takes a new request only when idle; the shared powering multiplier limits the rate.
// The front holds one queued request, so input is taken while the back end works.
// Reset (rst_n low, async): gain 0, gate open, attack off, configuration registers to defaults.
`include "loudness_gain_rider_defines.svh"
module loudness_gain_rider
    import lgr_pkg::*;
#(
    parameter int LEVEL_BITS = 16,
    parameter int COEFF_BITS = 16,
    parameter int MAX_BLOCK  = 8192
)
(
    input  logic clk,
    input  logic rst_n,
    lgr_stream_if.sink   in_ch,
    lgr_stream_if.sink   cfg,
    lgr_stream_if.source out_ch
);
    localparam int QW = LEVEL_BITS + SAMPLE_BITS;

    logic signed [LEVEL_BITS-1:0] target_reg, thresh_reg;
    logic [LEVEL_BITS-2:0] hyst_reg, maxcorr_reg, deadband_reg;
    logic [COEFF_BITS-1:0] attack_reg, release_reg;
    logic q_valid, q_ready, busy;
    logic [QW-1:0] q_data;
    logic [LEVEL_BITS-1:0] o_gain;
    logic o_gate, o_att;

    assign cfg.ready = 1'b1;

    // write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= LEVEL_BITS'(-5888);
            thresh_reg   <= LEVEL_BITS'(-15360);
            hyst_reg     <= (LEVEL_BITS-1)'(1536);
            maxcorr_reg  <= (LEVEL_BITS-1)'(3072);
            deadband_reg <= (LEVEL_BITS-1)'(256);
            attack_reg   <= COEFF_BITS'(65471);
            release_reg  <= COEFF_BITS'(65533);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data[LEVEL_BITS+COEFF_BITS +: 3])
                REG_TARGET:   target_reg   <= cfg.data[LEVEL_BITS-1:0];
                REG_THRESH:   thresh_reg   <= cfg.data[LEVEL_BITS-1:0];
                REG_HYST:     hyst_reg     <= cfg.data[LEVEL_BITS-2:0];
                REG_MAXCORR:  maxcorr_reg  <= cfg.data[LEVEL_BITS-2:0];
                REG_DEADBAND: deadband_reg <= cfg.data[LEVEL_BITS-2:0];
                REG_ATTACK:   attack_reg   <= cfg.data[COEFF_BITS-1:0];
                REG_RELEASE:  release_reg  <= cfg.data[COEFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    lgr_front #(.LEVEL_BITS(LEVEL_BITS), .MAX_BLOCK(MAX_BLOCK), .QW(QW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_level(in_ch.data[QW-1:SAMPLE_BITS]),
        .in_samples(in_ch.data[SAMPLE_BITS-1:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    lgr_back #(.LEVEL_BITS(LEVEL_BITS), .COEFF_BITS(COEFF_BITS), .QW(QW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .target(target_reg), .thresh(thresh_reg), .hyst(hyst_reg),
        .maxcorr(maxcorr_reg), .deadband(deadband_reg),
        .attack(attack_reg), .release_c(release_reg),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_gain(o_gain), .out_gate(o_gate), .out_att(o_att), .busy(busy)
    );

    assign out_ch.data = {o_gain, o_gate, o_att};

    `LGR_ASSERT(a_att_needs_gate, clk, rst_n, out_ch.valid && o_att |-> o_gate, "attack with gate closed")
    `LGR_ASSERT(a_take_idle, clk, rst_n, q_valid && q_ready |-> !busy, "queue pop while busy")
    `LGR_ASSERT_RST(a_rst_gate, clk, !rst_n |=> !out_ch.valid, "output valid after reset")
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lgr_pkg::*;

    localparam int  LVL_W       = 16;
    localparam int  IN_W        = LVL_W + SAMPLE_BITS;
    localparam int  CFG_W       = 3 + 32;
    localparam int  OUT_W       = LVL_W + 2;
    localparam int  MAX_SAMPLES = 8192;
    localparam int  SETTLE      = 80;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [LVL_W-1:0] gain;
        logic             gate_open;
        logic             attack;
    } gain_res_t;

    logic clk;
    logic rst_n;

    lgr_stream_if #(.W(IN_W))  in_ch ();
    lgr_stream_if #(.W(CFG_W)) cfg ();
    lgr_stream_if #(.W(OUT_W)) out_ch ();

    loudness_gain_rider i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg),
        .out_ch (out_ch)
    );

    // Local copy of the registers and the rider state
    longint          m_target;
    longint          m_thresh;
    longint          m_hyst;
    longint          m_maxcorr;
    longint          m_deadband;
    longint unsigned m_attack_c;
    longint unsigned m_release_c;
    longint          m_gain;
    bit              m_gate;
    bit              m_attack;

    logic [IN_W-1:0] level_req_q[$];
    gain_res_t       gain_exp_q[$];
    int              fails;
    int              accepted_reqs;
    bit              quiet;
    bit              hold_off;
    int              send_gap;
    int              recv_stall;
    longint          cycles;

    function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    // Raise a per-sample factor to the block length by repeated squaring
    function automatic longint unsigned q16_pow(longint unsigned base, int unsigned n);
        longint unsigned acc;
        acc = 64'd65536;
        while (n != 0) begin
            if (n[0])
                acc = q16_mul(acc, base);
            base = q16_mul(base, base);
            n = n >> 1;
        end
        return acc;
    endfunction

    function automatic longint scale_gain(longint x, longint unsigned c);
        longint r;
        r = longint'(q16_mul((x < 0) ? -x : x, c));
        return (x < 0) ? -r : r;
    endfunction

    // Advance the rider state by one request and return its result
    function automatic gain_res_t ride_gain(logic [IN_W-1:0] req);
        longint      lvl;
        int unsigned n;
        longint      g;
        longint      corr;
        longint      delta;
        bit          att_out;
        gain_res_t   res;
        lvl     = longint'($signed(req[IN_W-1:SAMPLE_BITS]));
        n       = req[SAMPLE_BITS-1:0];
        att_out = 1'b0;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        if (m_gate && 2 * lvl < 2 * m_thresh - m_hyst)
            m_gate = 1'b0;
        else if (!m_gate && 2 * lvl > 2 * m_thresh + m_hyst)
            m_gate = 1'b1;
        if (!m_gate) begin
            g = scale_gain(m_gain, q16_pow(m_release_c, n));
        end
        else begin
            corr = m_target - lvl;
            if (corr > m_maxcorr)
                corr = m_maxcorr;
            if (corr < -m_maxcorr)
                corr = -m_maxcorr;
            delta = ((corr < 0) ? -corr : corr) - ((m_gain < 0) ? -m_gain : m_gain);
            if (delta > m_deadband)
                m_attack = 1'b1;
            else if (delta < -m_deadband)
                m_attack = 1'b0;
            g = corr + scale_gain(m_gain - corr,
                                  q16_pow(m_attack ? m_attack_c : m_release_c, n));
            att_out = m_attack;
        end
        if (g > 32767)
            g = 32767;
        if (g < -32768)
            g = -32768;
        m_gain        = g;
        res.gain      = g[LVL_W-1:0];
        res.gate_open = m_gate;
        res.attack    = att_out;
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Request driver: predict on acceptance, then offer the next pending request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            send_gap    <= 0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                gain_exp_q.push_back(ride_gain(in_ch.data));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end
                else if (level_req_q.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= level_req_q.pop_front();
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 9);
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        gain_res_t got;
        gain_res_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (gain_exp_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fails++;
                end
                else begin
                    want = gain_exp_q.pop_front();
                    if (got.gain !== want.gain) begin
                        $display("%0t: gain expected %0d actual %0d", $time,
                                 $signed(want.gain), $signed(got.gain));
                        fails++;
                    end
                    if (got.gate_open !== want.gate_open) begin
                        $display("%0t: gate_is_open expected %b actual %b", $time,
                                 want.gate_open, got.gate_open);
                        fails++;
                    end
                    if (got.attack !== want.attack) begin
                        $display("%0t: attack_on expected %b actual %b", $time,
                                 want.attack, got.attack);
                        fails++;
                    end
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end
            else if (recv_stall > 0) begin
                out_ch.ready <= 1'b0;
                recv_stall   <= recv_stall - 1;
            end
            else begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    recv_stall <= $urandom_range(1, 9);
            end
        end
    end

    // Hold off the receiver for a long stretch so the block backs up
    initial
    begin
        hold_off = 1'b0;
        do @(posedge clk); while (accepted_reqs < 300);
        hold_off <= 1'b1;
        repeat (500) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= {idx, 16'h0000, val};
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_TARGET:   m_target    = longint'($signed(val));
            REG_THRESH:   m_thresh    = longint'($signed(val));
            REG_HYST:     m_hyst      = val[14:0];
            REG_MAXCORR:  m_maxcorr   = val[14:0];
            REG_DEADBAND: m_deadband  = val[14:0];
            REG_ATTACK:   m_attack_c  = val;
            REG_RELEASE:  m_release_c = val;
            default: ;
        endcase
    endtask

    task automatic write_all(int tgt, int thr, int hys, int mc, int db, int atk, int rel);
        write_reg(REG_TARGET, tgt[15:0]);
        write_reg(REG_THRESH, thr[15:0]);
        write_reg(REG_HYST, hys[15:0]);
        write_reg(REG_MAXCORR, mc[15:0]);
        write_reg(REG_DEADBAND, db[15:0]);
        write_reg(REG_ATTACK, atk[15:0]);
        write_reg(REG_RELEASE, rel[15:0]);
    endtask

    // Wait until every request has been taken and every result has come back
    task automatic drain();
        do @(posedge clk);
        while (level_req_q.size() != 0 || in_ch.valid || gain_exp_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] pack_req(int lvl, int n);
        return {lvl[15:0], n[SAMPLE_BITS-1:0]};
    endfunction

    function automatic int clip16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Random request: mostly near the gate edges or the target, some anywhere
    function automatic logic [IN_W-1:0] rand_req();
        int lvl;
        int n;
        int pick;
        int span;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            lvl = $signed(16'($urandom()));
        end
        else if (pick < 6) begin
            span = int'(m_hyst) / 2 + 64;
            lvl  = clip16(int'(m_thresh) + $signed($urandom_range(0, 2 * span)) - span);
        end
        else begin
            span = int'(m_maxcorr) + 256;
            if (span > 32767)
                span = 32767;
            lvl = clip16(int'(m_target) + $signed($urandom_range(0, 2 * span)) - span);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
            n = $urandom_range(1, 512);
        else if (pick < 9)
            n = $urandom_range(1, MAX_SAMPLES);
        else
            n = $urandom_range(0, 16383);
        return pack_req(lvl, n);
    endfunction

    initial
    begin
        int phase;
        m_target    = -5888;
        m_thresh    = -15360;
        m_hyst      = 1536;
        m_maxcorr   = 3072;
        m_deadband  = 256;
        m_attack_c  = 65471;
        m_release_c = 65533;
        m_gain      = 0;
        m_gate      = 1'b1;
        m_attack    = 1'b0;
        fails         = 0;
        accepted_reqs = 0;
        quiet         = 1'b0;
        cycles        = 0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, gate edges, attack swing, odd block lengths
        level_req_q.push_back(pack_req(32767, 1));
        level_req_q.push_back(pack_req(-32768, 8192));
        level_req_q.push_back(pack_req(-5888, 0));
        level_req_q.push_back(pack_req(-5888, 16383));
        level_req_q.push_back(pack_req(-12000, 8193));
        level_req_q.push_back(pack_req(-16128, 100));
        level_req_q.push_back(pack_req(-16129, 100));
        level_req_q.push_back(pack_req(-14592, 100));
        level_req_q.push_back(pack_req(-15000, 0));
        level_req_q.push_back(pack_req(-14591, 100));
        level_req_q.push_back(pack_req(-2816, 50));
        level_req_q.push_back(pack_req(-8960, 50));
        level_req_q.push_back(pack_req(-9000, 400));
        level_req_q.push_back(pack_req(-6000, 400));
        level_req_q.push_back(pack_req(0, 8192));
        level_req_q.push_back(pack_req(-1, 1));
        level_req_q.push_back(pack_req(-32768, 1));
        level_req_q.push_back(pack_req(21845, 2730));
        level_req_q.push_back(pack_req(-21846, 5461));
        level_req_q.push_back(pack_req(-20000, 3));
        drain();

        // Extreme settings, including odd hysteresis and edge coefficients
        write_all(32767, -32768, 32767, 32767, 0, 0, 65535);
        repeat (30) level_req_q.push_back(rand_req());
        drain();
        write_all(-32768, 32767, 0, 0, 32767, 65535, 0);
        repeat (30) level_req_q.push_back(rand_req());
        drain();
        write_all(-5888, -15360, 1, 32767, 0, 65535, 65535);
        repeat (40) level_req_q.push_back(rand_req());
        drain();

        // Random settings, random traffic; the last phase runs without gaps
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 7)
                quiet = 1'b1;
            write_all($signed(16'($urandom())), $signed(16'($urandom())),
                      $urandom_range(0, 4096), $urandom_range(0, 8192),
                      $urandom_range(0, 1024), $urandom_range(60000, 65535),
                      $urandom_range(60000, 65535));
            repeat (195) level_req_q.push_back(rand_req());
            drain();
        end

        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/lgr_pkg.sv
rtl/lgr_stream_if.sv
rtl/lgr_front.sv
rtl/lgr_back.sv
rtl/loudness_gain_rider.sv
sim/tb_top.sv
